/* src/rrts_pkg.sv */
// Shared types and constants for the round-robin thread scheduler.
// Depends on nothing; imported by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int THREADS   = 16;
    localparam int RESOURCES = 16;
    localparam int IDX_W     = $clog2(THREADS);
    localparam int CNT_W     = $clog2(THREADS + 1);

    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    typedef enum logic [2:0] {
        ST_UNDEF,
        ST_NEW,
        ST_RUNNABLE,
        ST_RUNNING,
        ST_WAITING,
        ST_BLOCKED,
        ST_SLEEPING,
        ST_DEAD
    } thr_state_t;

    typedef enum logic [2:0] {
        REQ_CREATE,
        REQ_START,
        REQ_SLEEP,
        REQ_BLOCK,
        REQ_EXIT,
        REQ_SCHEDULE,
        REQ_BEGIN,
        REQ_REMOVE
    } req_kind_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_WALK,
        FSM_COUNT,
        FSM_COMMIT,
        FSM_FIN
    } fsm_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  slot;
        logic [31:0] sleep_millis;
        logic [31:0] sleep_nanos;
        logic [3:0]  resource_id;
        logic [62:0] now_ns;
        logic [15:0] resource_busy;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] thread_id;
        logic [3:0]  running_slot;
        logic        running_valid;
        logic [4:0]  alive_count;
        logic        none_ready;
        logic [2:0]  slot_state;
    } rsp_t;

    typedef struct packed {
        thr_state_t       st;
        logic             ring;
        logic [IDX_W-1:0] nxt;
        logic [IDX_W-1:0] prv;
        logic [3:0]       res;
        logic [63:0]      wake;
    } rec_t;

    typedef struct packed {
        logic done;
        logic to_walk;
        logic to_count;
        logic to_commit;
    } step_t;

    function automatic logic res_busy(input logic [3:0] r, input logic [15:0] busy);
        return (32'(r) < RESOURCES) && busy[r];
    endfunction

endpackage

/* src/rrts_if.sv */
// Request and response channel interfaces of the thread scheduler.
// Depends on rrts_pkg for the payload types.
`timescale 1ns / 1ps

interface rrts_req_if import rrts_pkg::*;;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*;;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/round_robin_thread_scheduler_top.sv */
// Round-robin thread scheduler: slot table in one synchronous memory plus sequencer.
// Depends on rrts_pkg and the channel interfaces in rrts_if.sv.
//
// Usage:
//   req carries one request per transfer (create, start, sleep, block, exit,
//   schedule, begin, remove); rsp returns exactly one result per request.
//   Requests are handled one at a time. A new request is taken as soon as the
//   sequencer is back in idle, even while the previous result still waits on rsp.
//   Each request reads the slot records that it needs through the single
//   memory read port and writes back the changed ones. Sleep, block, begin
//   and exit skip reading the current record when there is none (begin then
//   reads the tail). Start and remove touch the neighbor records only when
//   accepted and a neighbor link changes; exit counts the live ring members;
//   schedule walks the ring, visiting at most THREADS members, and commits in
//   a further step when a woken thread is picked after the lap. The ring walk
//   reads one slot record per cycle.
//   Reset clears all slots to undef (per-entry valid bits, no clearing pass),
//   empties the ring and drops the current thread.
//   When rsp stalls, the finished result holds in the output register and the
//   next request is still accepted; its result waits until rsp drains.
`timescale 1ns / 1ps

module round_robin_thread_scheduler_top import rrts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    rrts_req_if.sink  req,
    rrts_rsp_if.source rsp
);

    fsm_t             fsm_reg, fsm_next;
    logic [2:0]       ph_reg, ph_next;
    req_t             r_reg, r_next;
    logic [51:0]      prod_reg;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             tv_reg, tv_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             cv_reg, cv_next;
    logic [31:0]      id_reg, id_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] start_reg, start_next;
    logic [IDX_W-1:0] fc_reg, fc_next;
    logic             fcv_reg, fcv_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [IDX_W-1:0] hn_reg, hn_next;
    logic [IDX_W-1:0] hp_reg, hp_next;
    rec_t             srec_reg, srec_next;
    logic             acc_reg, acc_next;
    logic [31:0]      tid_reg, tid_next;
    logic [CNT_W-1:0] alive_reg, alive_next;
    logic             none_reg, none_next;
    logic [2:0]       sst_reg, sst_next;
    rsp_t             out_reg, out_next;
    logic             ov_reg, ov_next;

    rec_t             mem [THREADS];
    logic [THREADS-1:0] vld_reg;
    rec_t             rdata_reg;
    logic             rvld_reg;
    rec_t             rd;
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    rec_t             wr_data;

    step_t            step;
    logic [IDX_W-1:0] sidx;
    logic             sok;
    logic             conv;
    logic             load_out;

    assign sidx = r_reg.slot[IDX_W-1:0];
    assign sok  = 32'(r_reg.slot) < THREADS;

    assign req.ready = (fsm_reg == FSM_IDLE);
    assign rsp.valid = ov_reg;
    assign rsp.data  = out_reg;
    assign load_out  = (fsm_reg == FSM_FIN) && (!ov_reg || rsp.ready);

    // slot record memory, read data forwarded on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr] || (wr_en && wr_addr == rd_addr);
            end
        end
    end

    always_comb
    begin
        rd = rdata_reg;
        if (!rvld_reg)
        begin
            rd.st   = ST_UNDEF;
            rd.ring = 1'b0;
            rd.wake = '0;
        end
    end

    assign conv = (rd.st == ST_RUNNING)
               || (rd.st == ST_SLEEPING && {1'b0, r_reg.now_ns} >= rd.wake)
               || (rd.st == ST_BLOCKED && !res_busy(rd.res, r_reg.resource_busy));

    // next state
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE:
            begin
                if (req.valid)
                begin
                    fsm_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (step.done)
                begin
                    fsm_next = FSM_FIN;
                end
                else if (step.to_walk)
                begin
                    fsm_next = FSM_WALK;
                end
                else if (step.to_count)
                begin
                    fsm_next = FSM_COUNT;
                end
            end
            FSM_WALK:
            begin
                if (step.done)
                begin
                    fsm_next = FSM_FIN;
                end
                else if (step.to_commit)
                begin
                    fsm_next = FSM_COMMIT;
                end
            end
            FSM_COUNT:
            begin
                if (step.done)
                begin
                    fsm_next = FSM_FIN;
                end
            end
            FSM_COMMIT:
            begin
                fsm_next = FSM_FIN;
            end
            FSM_FIN:
            begin
                if (load_out)
                begin
                    fsm_next = FSM_IDLE;
                end
            end
            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        step       = '0;
        ph_next    = ph_reg;
        r_next     = r_reg;
        tail_next  = tail_reg;
        tv_next    = tv_reg;
        cur_next   = cur_reg;
        cv_next    = cv_reg;
        id_next    = id_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        fc_next    = fc_reg;
        fcv_next   = fcv_reg;
        cnt_next   = cnt_reg;
        steps_next = steps_reg;
        hn_next    = hn_reg;
        hp_next    = hp_reg;
        srec_next  = srec_reg;
        acc_next   = acc_reg;
        tid_next   = tid_reg;
        alive_next = alive_reg;
        none_next  = none_reg;
        sst_next   = sst_reg;
        out_next   = out_reg;
        ov_next    = ov_reg && !rsp.ready;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = rd;

        unique case (fsm_reg)
            FSM_IDLE:
            begin
                if (req.valid)
                begin
                    r_next     = req.data;
                    ph_next    = '0;
                    acc_next   = 1'b0;
                    tid_next   = '0;
                    alive_next = '0;
                    none_next  = 1'b0;
                    sst_next   = ST_UNDEF;
                    fcv_next   = 1'b0;
                    cnt_next   = '0;
                    steps_next = '0;
                end
            end

            FSM_EXEC:
            begin
                unique case (req_kind_t'(r_reg.req_type))
                    REQ_CREATE:
                    begin
                        if (ph_reg == 3'd0)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = sidx;
                            ph_next = 3'd1;
                        end
                        else
                        begin
                            step.done = 1'b1;
                            if (sok && rd.st == ST_UNDEF)
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = sidx;
                                wr_data.st   = ST_NEW;
                                wr_data.ring = 1'b0;
                                wr_data.wake = '0;
                                id_next      = id_reg + 32'd1;
                                tid_next     = id_reg + 32'd1;
                                acc_next     = 1'b1;
                                sst_next     = ST_NEW;
                            end
                            else
                            begin
                                sst_next = sok ? rd.st : ST_UNDEF;
                            end
                        end
                    end

                    REQ_START:
                    begin
                        unique case (ph_reg)
                            3'd0:
                            begin
                                rd_en   = 1'b1;
                                rd_addr = sidx;
                                ph_next = 3'd1;
                            end
                            3'd1:
                            begin
                                srec_next = rd;
                                if (!(sok && rd.st == ST_NEW && !rd.ring))
                                begin
                                    sst_next  = sok ? rd.st : ST_UNDEF;
                                    step.done = 1'b1;
                                end
                                else if (tv_reg)
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = tail_reg;
                                    ph_next = 3'd2;
                                end
                                else
                                begin
                                    wr_en        = 1'b1;
                                    wr_addr      = sidx;
                                    wr_data.st   = ST_RUNNABLE;
                                    wr_data.ring = 1'b1;
                                    wr_data.nxt  = sidx;
                                    wr_data.prv  = sidx;
                                    tail_next    = sidx;
                                    tv_next      = 1'b1;
                                    acc_next     = 1'b1;
                                    sst_next     = ST_RUNNABLE;
                                    step.done    = 1'b1;
                                end
                            end
                            3'd2:
                            begin
                                hn_next     = rd.nxt;
                                wr_en       = 1'b1;
                                wr_addr     = tail_reg;
                                wr_data.nxt = sidx;
                                ph_next     = 3'd3;
                            end
                            3'd3:
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = sidx;
                                wr_data      = srec_reg;
                                wr_data.st   = ST_RUNNABLE;
                                wr_data.ring = 1'b1;
                                wr_data.nxt  = hn_reg;
                                wr_data.prv  = tail_reg;
                                rd_en        = 1'b1;
                                rd_addr      = hn_reg;
                                ph_next      = 3'd4;
                            end
                            default:
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = hn_reg;
                                wr_data.prv = sidx;
                                tail_next   = sidx;
                                acc_next    = 1'b1;
                                sst_next    = ST_RUNNABLE;
                                step.done   = 1'b1;
                            end
                        endcase
                    end

                    REQ_SLEEP, REQ_BLOCK:
                    begin
                        if (ph_reg == 3'd0)
                        begin
                            if (cv_reg)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = cur_reg;
                                ph_next = 3'd1;
                            end
                            else
                            begin
                                step.done = 1'b1;
                            end
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = cur_reg;
                            if (req_kind_t'(r_reg.req_type) == REQ_SLEEP)
                            begin
                                wr_data.wake = {1'b0, r_reg.now_ns} + 64'(prod_reg)
                                             + 64'(r_reg.sleep_nanos);
                                if (rd.st == ST_RUNNING)
                                begin
                                    wr_data.st = ST_SLEEPING;
                                    acc_next   = 1'b1;
                                end
                            end
                            else
                            begin
                                wr_data.res = r_reg.resource_id;
                                if (rd.st == ST_RUNNING)
                                begin
                                    wr_data.st = ST_BLOCKED;
                                    acc_next   = 1'b1;
                                end
                            end
                            sst_next  = wr_data.st;
                            step.done = 1'b1;
                        end
                    end

                    REQ_EXIT:
                    begin
                        if (ph_reg == 3'd0 && cv_reg)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = cur_reg;
                            ph_next = 3'd1;
                        end
                        else
                        begin
                            if (ph_reg != 3'd0)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = cur_reg;
                                if (rd.st == ST_RUNNING)
                                begin
                                    wr_data.st = ST_DEAD;
                                    acc_next   = 1'b1;
                                end
                                sst_next = wr_data.st;
                            end
                            if (tv_reg)
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = tail_reg;
                                pos_next      = tail_reg;
                                step.to_count = 1'b1;
                            end
                            else
                            begin
                                step.done = 1'b1;
                            end
                        end
                    end

                    REQ_SCHEDULE:
                    begin
                        unique case (ph_reg)
                            3'd0:
                            begin
                                if (cv_reg)
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = cur_reg;
                                    ph_next = 3'd1;
                                end
                                else if (tv_reg)
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = tail_reg;
                                    ph_next = 3'd2;
                                end
                                else
                                begin
                                    none_next = 1'b1;
                                    step.done = 1'b1;
                                end
                            end
                            3'd1:
                            begin
                                sst_next = rd.st;
                                if (rd.ring)
                                begin
                                    start_next   = cur_reg;
                                    pos_next     = cur_reg;
                                    rd_en        = 1'b1;
                                    rd_addr      = cur_reg;
                                    step.to_walk = 1'b1;
                                end
                                else if (tv_reg)
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = tail_reg;
                                    ph_next = 3'd2;
                                end
                                else
                                begin
                                    none_next = 1'b1;
                                    step.done = 1'b1;
                                end
                            end
                            default:
                            begin
                                start_next   = rd.nxt;
                                pos_next     = rd.nxt;
                                rd_en        = 1'b1;
                                rd_addr      = rd.nxt;
                                step.to_walk = 1'b1;
                            end
                        endcase
                    end

                    REQ_BEGIN:
                    begin
                        if (ph_reg == 3'd0)
                        begin
                            if (cv_reg || tv_reg)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = cv_reg ? cur_reg : tail_reg;
                                ph_next = 3'd1;
                            end
                            else
                            begin
                                step.done = 1'b1;
                            end
                        end
                        else
                        begin
                            step.done = 1'b1;
                            if (cv_reg)
                            begin
                                sst_next = rd.st;
                            end
                            else if (rd.st == ST_RUNNABLE)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = tail_reg;
                                wr_data.st = ST_RUNNING;
                                cur_next   = tail_reg;
                                cv_next    = 1'b1;
                                acc_next   = 1'b1;
                                sst_next   = ST_RUNNING;
                            end
                        end
                    end

                    REQ_REMOVE:
                    begin
                        unique case (ph_reg)
                            3'd0:
                            begin
                                rd_en   = 1'b1;
                                rd_addr = sidx;
                                ph_next = 3'd1;
                            end
                            3'd1:
                            begin
                                if (!(sok && rd.ring))
                                begin
                                    sst_next  = sok ? rd.st : ST_UNDEF;
                                    step.done = 1'b1;
                                end
                                else
                                begin
                                    sst_next     = rd.st;
                                    acc_next     = 1'b1;
                                    wr_en        = 1'b1;
                                    wr_addr      = sidx;
                                    wr_data.ring = 1'b0;
                                    if (rd.nxt == sidx && rd.prv == sidx)
                                    begin
                                        tv_next   = 1'b0;
                                        tail_next = '0;
                                        step.done = 1'b1;
                                    end
                                    else
                                    begin
                                        hn_next = rd.nxt;
                                        hp_next = rd.prv;
                                        rd_en   = 1'b1;
                                        rd_addr = rd.nxt;
                                        ph_next = 3'd2;
                                    end
                                end
                            end
                            3'd2:
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = hn_reg;
                                wr_data.prv = hp_reg;
                                rd_en       = 1'b1;
                                rd_addr     = hp_reg;
                                ph_next     = 3'd3;
                            end
                            default:
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = hp_reg;
                                wr_data.nxt = hn_reg;
                                if (tail_reg == sidx)
                                begin
                                    tail_next = hp_reg;
                                end
                                step.done = 1'b1;
                            end
                        endcase
                    end

                    default:
                    begin
                        step.done = 1'b1;
                    end
                endcase
            end

            FSM_WALK:
            begin
                if (rd.st == ST_RUNNABLE)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data.st = ST_RUNNING;
                    cur_next   = pos_reg;
                    cv_next    = 1'b1;
                    acc_next   = 1'b1;
                    sst_next   = ST_RUNNING;
                    step.done  = 1'b1;
                end
                else
                begin
                    if (conv)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = pos_reg;
                        wr_data.st = ST_RUNNABLE;
                        if (rd.st == ST_SLEEPING)
                        begin
                            wr_data.wake = '0;
                        end
                        if (!fcv_reg)
                        begin
                            fc_next  = pos_reg;
                            fcv_next = 1'b1;
                        end
                    end
                    if (rd.nxt == start_reg)
                    begin
                        // lap over: first thread woken in ring order gets the CPU
                        if (conv || fcv_reg)
                        begin
                            rd_en          = 1'b1;
                            rd_addr        = fcv_reg ? fc_reg : pos_reg;
                            pos_next       = rd_addr;
                            step.to_commit = 1'b1;
                        end
                        else
                        begin
                            none_next = 1'b1;
                            step.done = 1'b1;
                        end
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = rd.nxt;
                        pos_next = rd.nxt;
                    end
                end
            end

            FSM_COUNT:
            begin
                cnt_next   = cnt_reg + CNT_W'(rd.st != ST_DEAD);
                steps_next = steps_reg + CNT_W'(1);
                if (rd.nxt == tail_reg || steps_reg == CNT_W'(THREADS - 1))
                begin
                    alive_next = cnt_next;
                    step.done  = 1'b1;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd.nxt;
                    pos_next = rd.nxt;
                end
            end

            FSM_COMMIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data.st = ST_RUNNING;
                cur_next   = pos_reg;
                cv_next    = 1'b1;
                acc_next   = 1'b1;
                sst_next   = ST_RUNNING;
            end

            FSM_FIN:
            begin
                if (load_out)
                begin
                    out_next.accepted      = acc_reg;
                    out_next.thread_id     = tid_reg;
                    out_next.running_slot  = cv_reg ? 4'(cur_reg) : 4'd0;
                    out_next.running_valid = cv_reg;
                    out_next.alive_count   = 5'(alive_reg);
                    out_next.none_ready    = none_reg;
                    out_next.slot_state    = sst_reg;
                    ov_next                = 1'b1;
                end
            end

            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg  <= FSM_IDLE;
            ph_reg   <= '0;
            tail_reg <= '0;
            tv_reg   <= 1'b0;
            cur_reg  <= '0;
            cv_reg   <= 1'b0;
            id_reg   <= '0;
            fcv_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            fsm_reg  <= fsm_next;
            ph_reg   <= ph_next;
            tail_reg <= tail_next;
            tv_reg   <= tv_next;
            cur_reg  <= cur_next;
            cv_reg   <= cv_next;
            id_reg   <= id_next;
            fcv_reg  <= fcv_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        prod_reg  <= 52'(r_reg.sleep_millis) * 52'(NS_PER_MS);
        pos_reg   <= pos_next;
        start_reg <= start_next;
        fc_reg    <= fc_next;
        cnt_reg   <= cnt_next;
        steps_reg <= steps_next;
        hn_reg    <= hn_next;
        hp_reg    <= hp_next;
        srec_reg  <= srec_next;
        acc_reg   <= acc_next;
        tid_reg   <= tid_next;
        alive_reg <= alive_next;
        none_reg  <= none_next;
        sst_reg   <= sst_next;
        out_reg   <= out_next;
    end

endmodule

/* src/rrts_checker.sv */
// Port-level checks on the thread scheduler, bound to its top level.
// Depends on rrts_pkg and round_robin_thread_scheduler_top.
`timescale 1ns / 1ps

module rrts_checker import rrts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("rsp changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

    a_none_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.none_ready |-> !rsp_data.accepted)
        else $error("none_ready with accepted");

    a_slot_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.running_valid |-> rsp_data.running_slot == 4'd0)
        else $error("running_slot set without current thread");

    a_tid_on_create: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.thread_id != 32'd0
            |-> rsp_data.accepted && rsp_data.slot_state == ST_NEW)
        else $error("thread id without accepted create");

endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

/* sim/tb_top.sv */
// Testbench for the round-robin thread scheduler: directed table, then random requests.
// Depends on rrts_pkg, rrts_if.sv and round_robin_thread_scheduler_top; self-checking.
`timescale 1ns / 1ps

module tb_top;
    import rrts_pkg::*;

    logic clk;
    logic rst_n;

    rrts_req_if req_ch ();
    rrts_rsp_if rsp_ch ();

    round_robin_thread_scheduler_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    typedef struct {
        req_t req;
        logic chk;
        rsp_t rsp;
    } dir_row_t;

    thr_state_t  sched_st   [THREADS];
    logic [3:0]  sched_nxt  [THREADS];
    logic [3:0]  sched_prv  [THREADS];
    logic        sched_ring [THREADS];
    logic [63:0] sched_wake [THREADS];
    logic [3:0]  sched_res  [THREADS];
    logic [3:0]  tail_slot;
    logic        tail_ok;
    logic [3:0]  cur_slot;
    logic        cur_ok;
    logic [31:0] id_ctr;

    rsp_t     pending_rsp [$];
    dir_row_t dir_rows [$];
    int       errors;
    logic     idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic legal_move(thr_state_t from, thr_state_t to);
        case (from)
            ST_UNDEF:    return to == ST_NEW;
            ST_NEW:      return to == ST_RUNNABLE;
            ST_RUNNABLE: return to == ST_RUNNING;
            ST_RUNNING:  return to inside {ST_RUNNABLE, ST_DEAD, ST_SLEEPING, ST_BLOCKED};
            ST_BLOCKED, ST_SLEEPING: return to == ST_RUNNABLE;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic try_move(logic [3:0] s, thr_state_t to);
        if (!legal_move(sched_st[s], to))
            return 1'b0;
        sched_st[s] = to;
        return 1'b1;
    endfunction

    function automatic rsp_t predict_sched(req_t r);
        rsp_t        o;
        logic        slot_req;
        logic [3:0]  s;
        logic [3:0]  pos;
        logic [3:0]  p;
        logic        found;
        int          n;
        o = '0;
        slot_req = 1'b0;
        s = r.slot;
        case (req_kind_t'(r.req_type))
            REQ_CREATE:
            begin
                slot_req = 1'b1;
                if (sched_st[s] == ST_UNDEF)
                begin
                    id_ctr++;
                    o.thread_id = id_ctr;
                    sched_wake[s] = '0;
                    sched_ring[s] = 1'b0;
                    o.accepted = try_move(s, ST_NEW);
                end
            end
            REQ_START:
            begin
                slot_req = 1'b1;
                if (sched_st[s] == ST_NEW && !sched_ring[s])
                begin
                    o.accepted = try_move(s, ST_RUNNABLE);
                    if (tail_ok)
                    begin
                        sched_nxt[s] = sched_nxt[tail_slot];
                        sched_nxt[tail_slot] = s;
                        sched_prv[s] = tail_slot;
                        sched_prv[sched_nxt[s]] = s;
                    end
                    else
                    begin
                        sched_nxt[s] = s;
                        sched_prv[s] = s;
                    end
                    sched_ring[s] = 1'b1;
                    tail_slot = s;
                    tail_ok = 1'b1;
                end
            end
            REQ_SLEEP:
                if (cur_ok)
                begin
                    sched_wake[cur_slot] = {1'b0, r.now_ns} + 64'(r.sleep_millis) * 64'(NS_PER_MS)
                                           + 64'(r.sleep_nanos);
                    o.accepted = try_move(cur_slot, ST_SLEEPING);
                end
            REQ_BLOCK:
                if (cur_ok)
                begin
                    sched_res[cur_slot] = r.resource_id;
                    o.accepted = try_move(cur_slot, ST_BLOCKED);
                end
            REQ_EXIT:
            begin
                if (cur_ok)
                    o.accepted = try_move(cur_slot, ST_DEAD);
                n = 0;
                if (tail_ok)
                begin
                    p = tail_slot;
                    for (int i = 0; i < THREADS; i++)
                    begin
                        if (sched_st[p] != ST_DEAD)
                            n++;
                        p = sched_nxt[p];
                        if (p == tail_slot)
                            break;
                    end
                end
                o.alive_count = 5'(n);
            end
            REQ_SCHEDULE:
            begin
                found = 1'b0;
                if (cur_ok && sched_ring[cur_slot])
                    pos = cur_slot;
                else if (tail_ok)
                    pos = sched_nxt[tail_slot];
                else
                begin
                    o.none_ready = 1'b1;
                    pos = 'x;
                end
                if (!o.none_ready)
                begin
                    for (int i = 0; i < 2 * THREADS + 2; i++)
                    begin
                        if (sched_st[pos] == ST_RUNNABLE)
                        begin
                            found = 1'b1;
                            break;
                        end
                        if (sched_st[pos] == ST_RUNNING)
                            void'(try_move(pos, ST_RUNNABLE));
                        else if (sched_st[pos] == ST_SLEEPING)
                        begin
                            if ({1'b0, r.now_ns} >= sched_wake[pos])
                            begin
                                sched_wake[pos] = '0;
                                void'(try_move(pos, ST_RUNNABLE));
                            end
                        end
                        else if (sched_st[pos] == ST_BLOCKED)
                        begin
                            if (!r.resource_busy[sched_res[pos]])
                                void'(try_move(pos, ST_RUNNABLE));
                        end
                        pos = sched_nxt[pos];
                    end
                    if (found)
                    begin
                        cur_slot = pos;
                        cur_ok = 1'b1;
                        o.accepted = try_move(pos, ST_RUNNING);
                    end
                    else
                        o.none_ready = 1'b1;
                end
            end
            REQ_BEGIN:
                if (tail_ok && !cur_ok && sched_st[tail_slot] == ST_RUNNABLE)
                begin
                    cur_slot = tail_slot;
                    cur_ok = 1'b1;
                    o.accepted = try_move(tail_slot, ST_RUNNING);
                end
            default:
            begin
                slot_req = 1'b1;
                if (sched_ring[s])
                begin
                    if (sched_nxt[s] == s && sched_prv[s] == s)
                    begin
                        tail_ok = 1'b0;
                        tail_slot = '0;
                    end
                    else
                    begin
                        sched_prv[sched_nxt[s]] = sched_prv[s];
                        sched_nxt[sched_prv[s]] = sched_nxt[s];
                        if (tail_ok && tail_slot == s)
                            tail_slot = sched_prv[s];
                    end
                    sched_ring[s] = 1'b0;
                    o.accepted = 1'b1;
                end
            end
        endcase
        if (slot_req)
            o.slot_state = sched_st[s];
        else
            o.slot_state = cur_ok ? sched_st[cur_slot] : ST_UNDEF;
        o.running_slot = cur_ok ? cur_slot : '0;
        o.running_valid = cur_ok;
        return o;
    endfunction

    function automatic req_t make_req(req_kind_t k, logic [3:0] s, logic [62:0] now,
                                      logic [15:0] busy);
        req_t r;
        r = '0;
        r.req_type = k;
        r.slot = s;
        r.now_ns = now;
        r.resource_busy = busy;
        return r;
    endfunction

    function automatic rsp_t make_rsp(logic acc, logic [31:0] tid, logic [3:0] rs, logic rv,
                                      logic [4:0] alive, logic nr, thr_state_t st);
        rsp_t o;
        o.accepted = acc;
        o.thread_id = tid;
        o.running_slot = rs;
        o.running_valid = rv;
        o.alive_count = alive;
        o.none_ready = nr;
        o.slot_state = st;
        return o;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int   k;
        r.req_type = 3'($urandom_range(0, 7));
        k = $urandom_range(0, 99);
        if (k < 30)
            r.req_type = REQ_SCHEDULE;
        else if (k < 40)
            r.req_type = REQ_BEGIN;
        r.slot = 4'($urandom);
        r.sleep_millis = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 3));
        r.sleep_nanos = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 3000000));
        r.resource_id = 4'($urandom);
        if ($urandom_range(0, 19) == 0)
            r.now_ns = 63'({$urandom, $urandom});
        else
            r.now_ns = 63'($urandom_range(0, 20000000));
        r.resource_busy = 16'($urandom) & 16'($urandom);
        return r;
    endfunction

    task automatic send_req(req_t r, logic chk, rsp_t want);
        rsp_t exp_rsp;
        while (idle_on && $urandom_range(0, 99) < 26)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        exp_rsp = predict_sched(r);
        if (chk && exp_rsp !== want)
        begin
            $display("%0t directed row expected %h, predictor %h", $time, want, exp_rsp);
            errors++;
        end
        pending_rsp.push_back(exp_rsp);
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, rsp_ch.data);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.data !== want)
                begin
                    $display("%0t mismatch: expected %p, actual %p", $time, want, rsp_ch.data);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 26);
    end

    initial
    begin
        int cycles;
        errors = 0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        for (int i = 0; i < THREADS; i++)
        begin
            sched_st[i] = ST_UNDEF;
            sched_ring[i] = 1'b0;
            sched_wake[i] = '0;
            sched_nxt[i] = '0;
            sched_prv[i] = '0;
            sched_res[i] = '0;
        end
        tail_slot = '0;
        tail_ok = 1'b0;
        cur_slot = '0;
        cur_ok = 1'b0;
        id_ctr = '0;

        dir_rows.push_back('{make_req(REQ_SCHEDULE, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 1, ST_UNDEF)});
        dir_rows.push_back('{make_req(REQ_EXIT, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, ST_UNDEF)});
        dir_rows.push_back('{make_req(REQ_SLEEP, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, ST_UNDEF)});
        dir_rows.push_back('{make_req(REQ_BLOCK, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, ST_UNDEF)});
        dir_rows.push_back('{make_req(REQ_BEGIN, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, ST_UNDEF)});
        dir_rows.push_back('{make_req(REQ_REMOVE, 15, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, ST_UNDEF)});
        dir_rows.push_back('{make_req(REQ_START, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, ST_UNDEF)});
        dir_rows.push_back('{make_req(REQ_CREATE, 0, 0, 0), 1,
                             make_rsp(1, 1, 0, 0, 0, 0, ST_NEW)});
        dir_rows.push_back('{make_req(REQ_CREATE, 15, 0, 0), 1,
                             make_rsp(1, 2, 0, 0, 0, 0, ST_NEW)});
        dir_rows.push_back('{make_req(REQ_CREATE, 0, 0, 0), 1,
                             make_rsp(0, 0, 0, 0, 0, 0, ST_NEW)});
        dir_rows.push_back('{make_req(REQ_START, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_START, 15, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_BEGIN, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_SCHEDULE, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_BLOCK, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_SCHEDULE, 0, 0, 16'hFFFF), 0, '0});
        dir_rows.push_back('{make_req(REQ_SLEEP, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_SCHEDULE, 0, 0, 16'hFFFF), 0, '0});
        dir_rows.push_back('{make_req(REQ_SCHEDULE, 0, 63'h7FFFFFFFFFFFFFFF, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_REMOVE, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_EXIT, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_REMOVE, 15, 0, 0), 0, '0});
        dir_rows.push_back('{make_req(REQ_SCHEDULE, 0, 0, 0), 0, '0});
        dir_rows[14].req.resource_id = 4'hF;
        dir_rows[16].req.sleep_millis = 32'hFFFFFFFF;
        dir_rows[16].req.sleep_nanos = 32'hFFFFFFFF;
        dir_rows[16].req.now_ns = 63'h7FFFFFFFFFFFFFFF;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].rsp);
        for (int i = 0; i < 1800; i++)
        begin
            idle_on = !(i >= 600 && i < 900);
            send_req(rand_req(), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;
        idle_on = 1'b1;

        cycles = 0;
        while (pending_rsp.size() != 0 && cycles < 100000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
